/* src/heightmap_strip_normal_generator_defines.svh */
// Assertion macros shared by the strip normal generator RTL.
// Included by hsng_ctrl.sv and hsng_dp.sv; no other dependencies.
`ifndef HEIGHTMAP_STRIP_NORMAL_GENERATOR_DEFINES_SVH
`define HEIGHTMAP_STRIP_NORMAL_GENERATOR_DEFINES_SVH

// same-cycle implication
`define HSNG_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("hsng: assertion failed");

// next-cycle implication
`define HSNG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("hsng: assertion failed");

`endif

/* src/hsng_pkg.sv */
// Shared types and constants of the heightmap strip normal generator.
// No dependencies; imported by hsng_ctrl, hsng_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package hsng_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int GRID_W      = 11;
    localparam int SPACING_W   = 16;
    localparam int HEIGHT_W    = 16;
    localparam int POS_W       = 26;
    localparam int NORM_W      = 16;
    localparam int NUM_SLOTS   = 3;

    localparam logic [GRID_W-1:0]    COLS_RST    = 11'd3;
    localparam logic [GRID_W-1:0]    ROWS_RST    = 11'd3;
    localparam logic [SPACING_W-1:0] SPACING_RST = 16'd256;

    localparam int MW        = 31;  // multiplier operand width
    localparam int ACC_W     = 64;  // cross product / sum of squares
    localparam int SQ_RES_W  = 31;  // square root result width
    localparam int Q_W       = 15;  // quotient width
    localparam int STEP_W    = 5;
    localparam int MUL_OP_W  = 4;

    localparam int CROSS_OPS = 6;
    localparam int SQ_OPS    = 3;
    localparam int SQRT_STEPS = SQ_RES_W;
    localparam int DIV_STEPS  = Q_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS    = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_SPACING = 2'd2
    } cfg_idx_t;

    typedef enum logic [MUL_OP_W-1:0] {
        OP_C0A = 4'd0,
        OP_C0B = 4'd1,
        OP_C1A = 4'd2,
        OP_C1B = 4'd3,
        OP_C2A = 4'd4,
        OP_C2B = 4'd5,
        OP_SQ0 = 4'd6,
        OP_SQ1 = 4'd7,
        OP_SQ2 = 4'd8
    } mul_op_t;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        mul_op_t    mul_op;
        logic       mag_load;
        logic       norm_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       emit;
        logic [1:0] res_idx;
        logic       res_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] count;
        logic       need_norm;
        logic       mag_zero;
        logic       norm_ok;
        logic       out_free;
    } stat_t;

endpackage
`default_nettype wire

/* src/heightmap_strip_normal_generator.sv */
// Heightmap strip normal generator, top level: controller plus datapath.
// Depends on hsng_pkg, hsng_ctrl and hsng_dp.
//
// Takes one height transaction at a time and stalls the input until its
// results are handed to the output register. A sample that needs a normal
// goes through the cross product on the shared 31x31 multiplier, the
// normalization of the magnitudes, the sum of squares, the bit-serial square
// root and the three parallel restoring dividers, then one result
// transaction per cycle while the output is not stalled (three for the
// third vertex of a mesh). A zero cross product skips the sum of squares,
// square root and dividers. The next input is taken while the last result
// still waits at the output.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_strip_normal_generator
    import hsng_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [HEIGHT_W-1:0] height,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [POS_W-1:0]                pos_x,
    output logic signed [HEIGHT_W-1:0]      pos_y,
    output logic [POS_W-1:0]                pos_z,
    output logic signed [NORM_W-1:0]        norm_x,
    output logic signed [NORM_W-1:0]        norm_y,
    output logic signed [NORM_W-1:0]        norm_z,
    output logic                            mesh_last,
    output logic                            run_last,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data
);

    cmd_t  cmd;
    stat_t st;

    hsng_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    hsng_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .height    (height),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .mesh_last (mesh_last),
        .run_last  (run_last)
    );

endmodule
`default_nettype wire

/* src/hsng_ctrl.sv */
// Controller of the strip normal generator: sequences accept, cross product,
// normalize, square root, divide and result transactions. Uses hsng_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_strip_normal_generator_defines.svh"
module hsng_ctrl
    import hsng_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t st,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_CROSS = 9'b000000100,
        S_MAGS  = 9'b000001000,
        S_NORM  = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_SQRT  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          k_reg, k_next;
    logic                last_res;

    assign last_res = (k_reg == st.count - 2'd1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next = '0;
                k_next    = '0;
                if (st.count == 2'd0)
                    state_next = S_IDLE;
                else if (st.need_norm)
                    state_next = S_CROSS;
                else
                    state_next = S_EMIT;
            end
            S_CROSS:
            begin
                if (step_reg < STEP_W'(CROSS_OPS))
                begin
                    cmd.mul_en = 1'b1;
                    cmd.mul_op = mul_op_t'(step_reg[MUL_OP_W-1:0]);
                    step_next  = step_reg + 1'b1;
                end
                else
                begin
                    state_next = S_MAGS;
                end
            end
            S_MAGS:
            begin
                cmd.mag_load = 1'b1;
                state_next   = S_NORM;
            end
            S_NORM:
            begin
                step_next = '0;
                k_next    = '0;
                if (st.mag_zero)
                    state_next = S_EMIT;
                else if (st.norm_ok)
                    state_next = S_SQ;
                else
                    cmd.norm_step = 1'b1;
            end
            S_SQ:
            begin
                if (step_reg < STEP_W'(SQ_OPS))
                begin
                    cmd.mul_en = 1'b1;
                    cmd.mul_op = mul_op_t'(MUL_OP_W'(OP_SQ0) + step_reg[MUL_OP_W-1:0]);
                    step_next  = step_reg + 1'b1;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (step_reg == '0)
                begin
                    cmd.sqrt_init = 1'b1;
                    step_next     = step_reg + 1'b1;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    if (step_reg == STEP_W'(SQRT_STEPS))
                    begin
                        step_next  = '0;
                        state_next = S_DIV;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    cmd.div_init = 1'b1;
                    step_next    = step_reg + 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS))
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.res_idx  = k_reg;
                    cmd.res_last = last_res;
                    if (last_res)
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
        end
    end

    `HSNG_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, st.out_free)
    `HSNG_ASSERT_NEXT(a_accept_check, clk, rst_n, cmd.accept, state_reg == S_CHECK)

endmodule
`default_nettype wire

/* src/hsng_dp.sv */
// Datapath of the strip normal generator: grid counters, vertex slots, shared
// multiplier, normalizer, bit-serial square root and dividers, output register.
// Uses hsng_pkg; driven by hsng_ctrl.
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_strip_normal_generator_defines.svh"
module hsng_dp
    import hsng_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output stat_t                     st,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic signed [HEIGHT_W-1:0] height,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [POS_W-1:0]          pos_x,
    output logic signed [HEIGHT_W-1:0] pos_y,
    output logic [POS_W-1:0]          pos_z,
    output logic signed [NORM_W-1:0]  norm_x,
    output logic signed [NORM_W-1:0]  norm_y,
    output logic signed [NORM_W-1:0]  norm_z,
    output logic                      mesh_last,
    output logic                      run_last
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int XW    = COL_W + SPACING_W;
    localparam int ZW    = ROW_W + SPACING_W;
    localparam int RAD_W = 2 * SQ_RES_W;
    localparam int NUM_W = Q_W + SQ_RES_W - 1;

    // configuration
    logic [GRID_W-1:0]    grid_columns_reg, grid_rows_reg;
    logic [SPACING_W-1:0] grid_spacing_reg;
    logic [COL_W:0]       cols_eff;
    logic [ROW_W:0]       rows_eff;

    // grid walk
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             lower_reg;
    logic [1:0]       started_reg, started_next;
    logic [1:0]       slot_idx_reg, slot_new;
    logic             col_last, mesh_end;

    // event of the last accepted transaction
    logic [1:0] ev_count_reg;
    logic       ev_norm_reg, ev_fixed_reg, ev_mesh_end_reg;
    logic [1:0] ev_slot_reg;

    // vertex slots
    logic [XW-1:0]                 slot_x_reg [NUM_SLOTS];
    logic [ZW-1:0]                 slot_z_reg [NUM_SLOTS];
    logic signed [HEIGHT_BITS-1:0] slot_h_reg [NUM_SLOTS];
    logic signed [HEIGHT_BITS-1:0] h_in;
    logic [XW-1:0]                 x_new;
    logic [ZW-1:0]                 z_new;

    // multiplier and accumulators
    logic signed [MW-1:0]     ax, ay, az, bx, by, bz, op_a, op_b;
    logic signed [2*MW-1:0]   p_reg;
    mul_op_t                  p_op_reg;
    logic                     p_vld_reg;
    logic signed [ACC_W-1:0]  c_reg [3];
    logic [ACC_W-1:0]         sum_reg;

    // normalization
    logic [ACC_W-1:0] m_reg [3];
    logic             sgn_reg [3];
    logic [ACC_W-1:0] mx;

    // square root
    logic [RAD_W-1:0]    rad_reg;
    logic [SQ_RES_W+2:0] srem_reg;
    logic [SQ_RES_W-1:0] root_reg;
    logic [SQ_RES_W+4:0] srem_sh, strial;

    // dividers
    logic [SQ_RES_W-1:0] drem_reg [3];
    logic [Q_W-1:0]      dlow_reg [3];
    logic [Q_W-1:0]      q_reg [3];
    logic [NUM_W-1:0]    num [3];
    logic [SQ_RES_W:0]   dr2 [3];

    // output
    logic       out_valid_reg;
    logic [1:0] emit_slot;

    generate
        if (HEIGHT_BITS <= HEIGHT_W)
        begin : g_h_narrow
            assign h_in = height[HEIGHT_BITS-1:0];
        end
        else
        begin : g_h_wide
            assign h_in = {{(HEIGHT_BITS-HEIGHT_W){1'b0}}, height};
        end
    endgenerate

    always_comb
    begin
        cols_eff = (COL_W+1)'(grid_columns_reg);
        if (grid_columns_reg == '0)
            cols_eff = (COL_W+1)'(1);
        else if (32'(grid_columns_reg) > MAX_COLUMNS)
            cols_eff = (COL_W+1)'(MAX_COLUMNS);
        rows_eff = (ROW_W+1)'(grid_rows_reg);
        if (grid_rows_reg < 11'd2)
            rows_eff = (ROW_W+1)'(2);
        else if (32'(grid_rows_reg) > MAX_ROWS)
            rows_eff = (ROW_W+1)'(MAX_ROWS);
    end

    assign slot_new     = (slot_idx_reg == 2'd2) ? 2'd0 : slot_idx_reg + 2'd1;
    assign started_next = (started_reg == 2'd3) ? 2'd3 : started_reg + 2'd1;
    assign col_last     = ((COL_W+1)'(col_reg) + 1'b1) >= cols_eff;
    assign mesh_end     = lower_reg && col_last && (((ROW_W+1)'(row_reg) + 2'd2) >= rows_eff);
    assign x_new        = XW'(col_reg) * XW'(grid_spacing_reg);
    assign z_new        = ZW'(ROW_W'(row_reg) + ROW_W'(lower_reg)) * ZW'(grid_spacing_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= COLS_RST;
            grid_rows_reg    <= ROWS_RST;
            grid_spacing_reg <= SPACING_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            lower_reg        <= 1'b0;
            started_reg      <= '0;
            slot_idx_reg     <= '0;
            ev_count_reg     <= '0;
            ev_norm_reg      <= 1'b0;
            ev_fixed_reg     <= 1'b0;
            ev_mesh_end_reg  <= 1'b0;
            ev_slot_reg      <= '0;
            p_vld_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLS:    grid_columns_reg <= cfg_data[GRID_W-1:0];
                    CFG_ROWS:    grid_rows_reg    <= cfg_data[GRID_W-1:0];
                    CFG_SPACING: grid_spacing_reg <= cfg_data[SPACING_W-1:0];
                    default:     ;
                endcase
            end
            if (cmd.accept)
            begin
                ev_slot_reg     <= slot_new;
                ev_mesh_end_reg <= mesh_end;
                if (started_next == 2'd3)
                begin
                    ev_norm_reg  <= 1'b1;
                    ev_fixed_reg <= (started_reg == 2'd2);
                    ev_count_reg <= (started_reg == 2'd2) ? 2'd3 : 2'd1;
                end
                else
                begin
                    ev_norm_reg  <= 1'b0;
                    ev_fixed_reg <= 1'b1;
                    ev_count_reg <= mesh_end ? started_next : 2'd0;
                end
                if (mesh_end)
                begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    lower_reg    <= 1'b0;
                    started_reg  <= '0;
                    slot_idx_reg <= '0;
                end
                else
                begin
                    started_reg  <= started_next;
                    slot_idx_reg <= slot_new;
                    if (!lower_reg)
                        lower_reg <= 1'b1;
                    else
                    begin
                        lower_reg <= 1'b0;
                        if (col_last)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
            end
            p_vld_reg <= cmd.mul_en;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // cross product operands
    assign ax = MW'(slot_x_reg[1]) - MW'(slot_x_reg[0]);
    assign bx = MW'(slot_x_reg[2]) - MW'(slot_x_reg[0]);
    assign az = MW'(slot_z_reg[1]) - MW'(slot_z_reg[0]);
    assign bz = MW'(slot_z_reg[2]) - MW'(slot_z_reg[0]);
    assign ay = MW'(slot_h_reg[1]) - MW'(slot_h_reg[0]);
    assign by = MW'(slot_h_reg[2]) - MW'(slot_h_reg[0]);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_op)
            OP_C0A: begin op_a = ay; op_b = bz; end
            OP_C0B: begin op_a = az; op_b = by; end
            OP_C1A: begin op_a = az; op_b = bx; end
            OP_C1B: begin op_a = ax; op_b = bz; end
            OP_C2A: begin op_a = ax; op_b = by; end
            OP_C2B: begin op_a = ay; op_b = bx; end
            OP_SQ0: begin op_a = m_reg[0][MW-1:0]; op_b = m_reg[0][MW-1:0]; end
            OP_SQ1: begin op_a = m_reg[1][MW-1:0]; op_b = m_reg[1][MW-1:0]; end
            OP_SQ2: begin op_a = m_reg[2][MW-1:0]; op_b = m_reg[2][MW-1:0]; end
            default: ;
        endcase
    end

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
            mx = m_reg[1];
        if (m_reg[2] > mx)
            mx = m_reg[2];
    end

    // square root recurrence, two radicand bits per step
    assign srem_sh = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign strial  = {3'b000, root_reg, 2'b01};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = (NUM_W'(m_reg[i][SQ_RES_W-2:0]) << (Q_W - 1))
                     + NUM_W'(root_reg[SQ_RES_W-1:1]);
            dr2[i] = {drem_reg[i], dlow_reg[i][Q_W-1]};
        end
    end

    always_comb
    begin
        emit_slot = ev_slot_reg;
        if (ev_fixed_reg)
        begin
            case (cmd.res_idx)
                2'd0:    emit_slot = 2'd1;
                2'd1:    emit_slot = 2'd2;
                default: emit_slot = 2'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_x_reg[slot_new] <= x_new;
            slot_z_reg[slot_new] <= z_new;
            slot_h_reg[slot_new] <= h_in;
            for (int i = 0; i < 3; i++)
                q_reg[i] <= '0;
        end
        if (cmd.mul_en)
        begin
            p_reg    <= op_a * op_b;
            p_op_reg <= cmd.mul_op;
        end
        if (p_vld_reg)
        begin
            case (p_op_reg)
                OP_C0A:  c_reg[0] <= ACC_W'(p_reg);
                OP_C0B:  c_reg[0] <= c_reg[0] - ACC_W'(p_reg);
                OP_C1A:  c_reg[1] <= ACC_W'(p_reg);
                OP_C1B:  c_reg[1] <= c_reg[1] - ACC_W'(p_reg);
                OP_C2A:  c_reg[2] <= ACC_W'(p_reg);
                OP_C2B:  c_reg[2] <= c_reg[2] - ACC_W'(p_reg);
                OP_SQ0:  sum_reg  <= ACC_W'(p_reg);
                default: sum_reg  <= sum_reg + ACC_W'(p_reg);
            endcase
        end
        if (cmd.mag_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sgn_reg[i] <= c_reg[i][ACC_W-1];
                m_reg[i]   <= c_reg[i][ACC_W-1] ? ACC_W'(-c_reg[i]) : ACC_W'(c_reg[i]);
            end
        end
        else if (cmd.norm_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (mx[ACC_W-1:34] != '0)
                    m_reg[i] <= m_reg[i] >> 4;
                else if (mx[33:30] != '0)
                    m_reg[i] <= m_reg[i] >> 1;
                else if (mx[29:25] == '0)
                    m_reg[i] <= m_reg[i] << 4;
                else
                    m_reg[i] <= m_reg[i] << 1;
            end
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= sum_reg[RAD_W-1:0];
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (srem_sh >= strial)
            begin
                srem_reg <= (SQ_RES_W+3)'(srem_sh - strial);
                root_reg <= {root_reg[SQ_RES_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= (SQ_RES_W+3)'(srem_sh);
                root_reg <= {root_reg[SQ_RES_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[i] <= SQ_RES_W'(num[i][NUM_W-1:Q_W]);
                dlow_reg[i] <= num[i][Q_W-1:0];
                q_reg[i]    <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dlow_reg[i] <= dlow_reg[i] << 1;
                if (dr2[i] >= {1'b0, root_reg})
                begin
                    drem_reg[i] <= SQ_RES_W'(dr2[i] - {1'b0, root_reg});
                    q_reg[i]    <= {q_reg[i][Q_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[i] <= SQ_RES_W'(dr2[i]);
                    q_reg[i]    <= {q_reg[i][Q_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.emit)
        begin
            pos_x     <= POS_W'(slot_x_reg[emit_slot]);
            pos_y     <= HEIGHT_W'(slot_h_reg[emit_slot]);
            pos_z     <= POS_W'(slot_z_reg[emit_slot]);
            norm_x    <= sgn_reg[0] ? -NORM_W'(q_reg[0]) : NORM_W'(q_reg[0]);
            norm_y    <= sgn_reg[1] ? -NORM_W'(q_reg[1]) : NORM_W'(q_reg[1]);
            norm_z    <= sgn_reg[2] ? -NORM_W'(q_reg[2]) : NORM_W'(q_reg[2]);
            run_last  <= cmd.res_last;
            mesh_last <= cmd.res_last && ev_mesh_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign st.count     = ev_count_reg;
    assign st.need_norm = ev_norm_reg;
    assign st.mag_zero  = (mx == '0);
    assign st.norm_ok   = (mx[ACC_W-1:30] == '0) && mx[29];
    assign st.out_free  = !out_valid_reg || !out_stall;

    `HSNG_ASSERT_IMPL(a_div_len, clk, rst_n, cmd.div_init,
        root_reg[SQ_RES_W-1:SQ_RES_W-2] != 2'b00)
    `HSNG_ASSERT_IMPL(a_emit_idx, clk, rst_n, cmd.emit, cmd.res_idx < ev_count_reg)

endmodule
`default_nettype wire

/* tb/heightmap_strip_normal_generator_tb.sv */
// Testbench for heightmap_strip_normal_generator: directed table, then random phases.
// Uses a local strip/normal predictor for expected results; depends on hsng_pkg and the RTL.
`timescale 1ns / 1ps
module heightmap_strip_normal_generator_tb;
    import hsng_pkg::*;

    typedef struct {
        logic [POS_W-1:0]           px;
        logic signed [HEIGHT_W-1:0] py;
        logic [POS_W-1:0]           pz;
        logic signed [NORM_W-1:0]   nx;
        logic signed [NORM_W-1:0]   ny;
        logic signed [NORM_W-1:0]   nz;
        logic                       ml;
        logic                       rl;
    } vertex_t;

    typedef struct {
        bit                  is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]    value;
        bit                  flat;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [HEIGHT_W-1:0] height;
    logic                       out_valid;
    logic                       out_stall;
    logic [POS_W-1:0]           pos_x;
    logic signed [HEIGHT_W-1:0] pos_y;
    logic [POS_W-1:0]           pos_z;
    logic signed [NORM_W-1:0]   norm_x;
    logic signed [NORM_W-1:0]   norm_y;
    logic signed [NORM_W-1:0]   norm_z;
    logic                       mesh_last;
    logic                       run_last;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    heightmap_strip_normal_generator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .height(height),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .mesh_last(mesh_last), .run_last(run_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;

    vertex_t     vertex_q[$];
    int unsigned mismatches;
    int unsigned accepted_heights;
    int unsigned idle_cycles;
    bit          flat_expected;
    int          stall_mode;

    // predictor state
    int unsigned grid_cols, grid_rows, grid_spacing;
    int unsigned col_cnt, row_cnt, lower_half, started, slot;
    longint      slot_x[NUM_SLOTS], slot_z[NUM_SLOTS], slot_h[NUM_SLOTS];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic face_normal(output longint n[3]);
        longint ax, ay, az, bx, by, bz;
        longint c[3];
        longint unsigned m[3], mx, len;
        ax = slot_x[1] - slot_x[0];
        ay = slot_h[1] - slot_h[0];
        az = slot_z[1] - slot_z[0];
        bx = slot_x[2] - slot_x[0];
        by = slot_h[2] - slot_h[0];
        bz = slot_z[2] - slot_z[0];
        c[0] = ay * bz - az * by;
        c[1] = az * bx - ax * bz;
        c[2] = ax * by - ay * bx;
        for (int i = 0; i < 3; i++) m[i] = c[i] < 0 ? -c[i] : c[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        n[0] = 0; n[1] = 0; n[2] = 0;
        if (mx == 0) return;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = longint'((m[i] * 16384 + len / 2) / len);
            n[i] = c[i] < 0 ? -q : q;
        end
    endtask

    function automatic vertex_t slot_vertex(int s, longint n[3]);
        vertex_t v;
        v.px = slot_x[s][POS_W-1:0];
        v.py = slot_h[s][HEIGHT_W-1:0];
        v.pz = slot_z[s][POS_W-1:0];
        v.nx = n[0][NORM_W-1:0];
        v.ny = n[1][NORM_W-1:0];
        v.nz = n[2][NORM_W-1:0];
        v.ml = 1'b0;
        v.rl = 1'b0;
        return v;
    endfunction

    task automatic predict_vertices(logic signed [HEIGHT_W-1:0] h, bit flat);
        int unsigned cols, rows, prev_started;
        longint      n[3];
        vertex_t     res[3];
        int          count;
        bit          mesh_end;
        cols = grid_cols < 1 ? 1 : (grid_cols > MAX_COLUMNS_DEF ? MAX_COLUMNS_DEF : grid_cols);
        rows = grid_rows < 2 ? 2 : (grid_rows > MAX_ROWS_DEF ? MAX_ROWS_DEF : grid_rows);
        n[0] = 0; n[1] = 0; n[2] = 0;
        count = 0;
        slot = (slot + 1) % NUM_SLOTS;
        slot_x[slot] = longint'(col_cnt) * grid_spacing;
        slot_z[slot] = longint'(row_cnt + lower_half) * grid_spacing;
        slot_h[slot] = h;
        prev_started = started;
        if (started < 3) started++;
        mesh_end = lower_half != 0 && col_cnt + 1 >= cols && row_cnt + 2 >= rows;
        if (lower_half == 0)
            lower_half = 1;
        else begin
            lower_half = 0;
            if (col_cnt + 1 >= cols) begin
                col_cnt = 0;
                row_cnt++;
            end
            else
                col_cnt++;
        end
        if (started == 3) begin
            face_normal(n);
            if (flat) begin
                n[0] = 0; n[1] = 0; n[2] = 0;
            end
            if (prev_started == 2) begin
                res[0] = slot_vertex(1, n);
                res[1] = slot_vertex(2, n);
                res[2] = slot_vertex(0, n);
                count = 3;
            end
            else begin
                res[0] = slot_vertex(slot, n);
                count = 1;
            end
        end
        else if (mesh_end) begin
            res[0] = slot_vertex(1, n);
            count = 1;
            if (started == 2) begin
                res[1] = slot_vertex(2, n);
                count = 2;
            end
        end
        if (count > 0) begin
            res[count-1].rl = 1'b1;
            res[count-1].ml = mesh_end;
        end
        for (int i = 0; i < count; i++) vertex_q.insert(vertex_q.size(), res[i]);
        if (mesh_end) begin
            col_cnt = 0; row_cnt = 0; lower_half = 0; started = 0; slot = 0;
        end
    endtask

    // input side and register writes
    always @(posedge clk) begin
        if (rst_n && cfg_we) begin
            case (cfg_index)
                CFG_COLS:    grid_cols    = cfg_data & 16'h7FF;
                CFG_ROWS:    grid_rows    = cfg_data & 16'h7FF;
                CFG_SPACING: grid_spacing = cfg_data;
                default:     ;
            endcase
        end
        if (rst_n && in_valid && !in_stall) begin
            predict_vertices(height, flat_expected);
            accepted_heights++;
        end
    end

    // output side
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            vertex_t e;
            idle_cycles = 0;
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: x=%0d y=%0d z=%0d",
                             pos_x, pos_y, pos_z);
            end
            else begin
                e = vertex_q.pop_front();
                if (pos_x !== e.px || pos_y !== e.py || pos_z !== e.pz ||
                    norm_x !== e.nx || norm_y !== e.ny || norm_z !== e.nz ||
                    mesh_last !== e.ml || run_last !== e.rl) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp pos=(%0d,%0d,%0d) n=(%0d,%0d,%0d) ml=%b rl=%b",
                                 e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.ml, e.rl);
                        $display("          got pos=(%0d,%0d,%0d) n=(%0d,%0d,%0d) ml=%b rl=%b",
                                 pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                 mesh_last, run_last);
                    end
                end
            end
        end
        else if (rst_n && in_valid && !in_stall)
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("heightmap_strip_normal_generator_tb: FAIL");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk) begin
        if (($urandom % 64) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom % 4) == 0;
            2: out_stall = ($urandom % 4) != 0;
            default: out_stall = ($urandom % 2) == 0;
        endcase
    end

    int burst_left;

    task automatic send_height(logic signed [HEIGHT_W-1:0] h, bit flat);
        int unsigned seen;
        if (burst_left == 0) begin
            int gap;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        flat_expected = flat;
        height = h;
        in_valid = 1'b1;
        seen = accepted_heights;
        do @(negedge clk); while (accepted_heights == seen);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (vertex_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_cols();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1024;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_rows();
        case ($urandom_range(0, 9))
            0: return 16'd1;
            1: return 16'hF800 | 16'($urandom_range(2, 4));
            2: return 16'd2047;
            default: return 16'($urandom_range(2, 5));
        endcase
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 3))
            0: return HEIGHT_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    stim_row_t directed[] = '{
        '{0, CFG_COLS, 16'd0, 0}, '{0, CFG_COLS, 16'h7FFF, 0},
        '{0, CFG_COLS, 16'h8000, 0}, '{0, CFG_COLS, 16'd0, 0},
        '{0, CFG_COLS, 16'd1, 0}, '{0, CFG_COLS, 16'hFFFF, 0},
        '{0, CFG_COLS, 16'h0100, 0}, '{0, CFG_COLS, 16'hFF00, 0},
        '{0, CFG_COLS, 16'h7FFF, 0}, '{0, CFG_COLS, 16'h8000, 0},
        '{0, CFG_COLS, 16'd5, 0}, '{0, CFG_COLS, 16'hFFFB, 0},
        '{1, CFG_SPACING, 16'd0, 0}, '{1, CFG_COLS, 16'd1, 0},
        '{1, CFG_ROWS, 16'd0, 0},
        '{0, CFG_COLS, 16'd300, 1}, '{0, CFG_COLS, 16'hFED4, 1},
        '{1, CFG_ROWS, 16'd3, 0},
        '{0, CFG_COLS, 16'h7FFF, 1}, '{0, CFG_COLS, 16'h8000, 1},
        '{0, CFG_COLS, 16'd1, 1}, '{0, CFG_COLS, 16'd2, 1},
        '{1, CFG_COLS, 16'hFFFF, 0}, '{1, CFG_ROWS, 16'h07FF, 0},
        '{1, CFG_SPACING, 16'hFFFF, 0}, '{1, 2'd3, 16'hA5A5, 0},
        '{0, CFG_COLS, 16'h7FFF, 0}, '{0, CFG_COLS, 16'h8000, 0},
        '{0, CFG_COLS, 16'h1234, 0}, '{0, CFG_COLS, 16'hEDCC, 0},
        '{0, CFG_COLS, 16'd0, 0}
    };

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        height = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_COLS;
        cfg_data = '0;
        mismatches = 0;
        accepted_heights = 0;
        idle_cycles = 0;
        flat_expected = 0;
        stall_mode = 0;
        burst_left = 0;
        grid_cols = COLS_RST;
        grid_rows = ROWS_RST;
        grid_spacing = SPACING_RST;
        col_cnt = 0; row_cnt = 0; lower_half = 0; started = 0; slot = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_x[i] = 0; slot_z[i] = 0; slot_h[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: register rows drain the results and write idx; data rows send value as a height
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                drain_results();
                write_reg(directed[i].idx, directed[i].value);
            end
            else
                send_height(directed[i].value, directed[i].flat);
        end

        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            write_reg(CFG_COLS, pick_cols());
            write_reg(CFG_ROWS, pick_rows());
            write_reg(CFG_SPACING, phase == 2 ? 16'd0 : 16'($urandom));
            if ($urandom_range(0, 1)) write_reg(2'd3, 16'($urandom));
            for (int k = 0; k < 40; k++) send_height(pick_height(), 0);
        end

        drain_results();
        if (mismatches == 0 && vertex_q.size() == 0)
            $display("heightmap_strip_normal_generator_tb: PASS");
        else
            $display("heightmap_strip_normal_generator_tb: FAIL");
        $finish;
    end

endmodule
